### src/dct_pkg.sv
// dct_pkg: transaction types and fixed codes of the dependency counter table
// depends on nothing; imported by every module of the block
package dct_pkg;

  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned GEN_W    = 16;
  localparam int unsigned IDF_W    = 16;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned WORKER_W = 8;

  localparam logic [1:0] KIND_INC    = 2'd0;
  localparam logic [1:0] KIND_DEC    = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_SUBMIT = 2'd3;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NO_SLOT    = 2'd1;
  localparam logic [1:0] STATUS_STALE      = 2'd2;
  localparam logic [1:0] STATUS_CHAIN_FULL = 2'd3;

  typedef struct packed {
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] target_handle;
    logic                target_valid;
    logic [HANDLE_W-1:0] precondition_handle;
    logic                precondition_valid;
    logic [TAG_W-1:0]    job_tag;
    logic [WORKER_W-1:0] job_worker;
  } in_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic                handle_out_valid;
    logic                is_zero;
    logic                released;
    logic [TAG_W-1:0]    rel_job_tag;
    logic [WORKER_W-1:0] rel_worker;
    logic [HANDLE_W-1:0] rel_finish_handle;
    logic                rel_finish_valid;
    logic                last;
    logic [1:0]          status;
  } out_item_t;

  localparam out_item_t OUT_NONE = '{last: 1'b1, default: '0};

endpackage

### src/dct_ram.sv
// dct_ram: one-write one-read synchronous memory, registered read data
// same-cycle write to the read address is forwarded; uses dct_pkg
module dct_ram
  import dct_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/dct_out_reg.sv
// dct_out_reg: result output register between the sequencer and the out channel
// uses dct_pkg for the result transaction type
module dct_out_reg
  import dct_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_data,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data,
  output logic      free
);

  logic      valid_r;
  out_item_t data_r;

  assign free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### src/dependency_counter_table.sv
// dependency_counter_table: generational handle counter pool with waiter chains
// depends on dct_pkg, dct_ram (slot table and free stack), dct_out_reg
//
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    in_item_t  (kind, handles, job)
// out      output     out_valid/out_ready  out_item_t (handle, release, status)
//
// sequencing: one transaction in flight; a release walks the chain and a
//   submit counts its slots one at a time, at most MAX_WAITERS slots; the
//   single read port of the slot table paces every step
// reset: a clearing pass writes every slot and rebuilds the free stack;
//   in_ready stays low until it is done
// stalls: a finished result waits in the output register while the next
//   transaction is taken; a release walk pauses only when a second job is
//   ready while the output register is still full
module dependency_counter_table
  import dct_pkg::*;
#(
  parameter int unsigned POOL_SIZE   = 4096,
  parameter int unsigned MAX_WAITERS = 63,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned ID_W   = $clog2(POOL_SIZE);
  localparam int unsigned LINK_W = ID_W + 1;
  localparam int unsigned TOP_W  = ID_W + 1;
  localparam int unsigned STEP_W = $clog2(MAX_WAITERS + 1);
  localparam logic [ID_W-1:0]       LAST_ID   = ID_W'(POOL_SIZE - 1);
  localparam logic [TOP_W-1:0]      TOP_FULL  = TOP_W'(POOL_SIZE);
  localparam logic [STEP_W-1:0]     STEP_MAX  = STEP_W'(MAX_WAITERS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [LINK_W-1:0]     LINK_NONE = {1'b1, {ID_W{1'b0}}};

  // one table word per slot; link msb set means end of chain
  typedef struct packed {
    logic [GEN_W-1:0]      gen;
    logic [COUNT_BITS-1:0] count;
    logic                  present;
    logic [TAG_W-1:0]      tag;
    logic [WORKER_W-1:0]   worker;
    logic                  fin_valid;
    logic [HANDLE_W-1:0]   fin_handle;
    logic [LINK_W-1:0]     link;
  } slot_rec_t;

  localparam slot_rec_t REC_CLEAR = '{link: LINK_NONE, default: '0};

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_T_CHK, ST_P_CHK, ST_CW_EV, ST_DECIDE, ST_JOB,
    ST_POP_RD, ST_POP_SL, ST_POP_WR, ST_LK_CAP, ST_CH_WR, ST_PL_WR, ST_JW,
    ST_REL_WR, ST_REL_END
  } state_t;

  typedef enum logic [1:0] {POP_ALLOC, POP_FIN, POP_CHAIN} pop_mode_t;

  // ST_RES folded: results wait in res_r for the output register
  state_t    state_r, state_nxt;
  logic      res_pend_r, res_pend_nxt;
  in_item_t  in_r, in_nxt;
  logic      tlive_r, tlive_nxt;
  logic      plive_r, plive_nxt;
  logic      pchain_r, pchain_nxt;
  logic [ID_W-1:0]   cur_r, cur_nxt;
  logic [ID_W-1:0]   new_id_r, new_id_nxt;
  logic [ID_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [STEP_W-1:0] wcnt_r, wcnt_nxt;
  logic [TOP_W-1:0]  top_r, top_nxt;
  logic [HANDLE_W-1:0] fh_r, fh_nxt;
  logic [LINK_W-1:0] plink_r, plink_nxt;
  slot_rec_t rec_t_r, rec_t_nxt;
  pop_mode_t pop_mode_r, pop_mode_nxt;
  out_item_t res_r, res_nxt;
  out_item_t pend_r, pend_nxt;
  logic      pend_v_r, pend_v_nxt;

  // memory ports
  logic            s_we, s_re;
  logic [ID_W-1:0] s_waddr, s_raddr;
  slot_rec_t       s_wdata, s_rdata;
  logic            k_we, k_re;
  logic [ID_W-1:0] k_waddr, k_raddr, k_wdata, k_rdata;

  logic      out_load, out_free;
  out_item_t out_load_data;

  dct_ram #(.WIDTH($bits(slot_rec_t)), .DEPTH(POOL_SIZE)) u_slot_ram (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .re   (s_re),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  dct_ram #(.WIDTH(ID_W), .DEPTH(POOL_SIZE)) u_stack_ram (
    .clk  (clk),
    .we   (k_we),
    .waddr(k_waddr),
    .wdata(k_wdata),
    .re   (k_re),
    .raddr(k_raddr),
    .rdata(k_rdata)
  );

  dct_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (out_load),
    .load_data(out_load_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data),
    .free     (out_free)
  );

  // a handle is live when its id is in the pool, generations agree and count is nonzero
  function automatic logic slot_live(slot_rec_t rec, logic [HANDLE_W-1:0] h);
    logic in_pool;
    in_pool = ({1'b0, h[IDF_W-1:0]} < (IDF_W + 1)'(POOL_SIZE));
    return in_pool && (rec.gen == h[HANDLE_W-1:IDF_W]) && (rec.count != '0);
  endfunction

  function automatic slot_rec_t bump(slot_rec_t rec);
    slot_rec_t r;
    r = rec;
    if (rec.count != COUNT_MAX) begin
      r.count = rec.count + COUNT_ONE;
    end
    return r;
  endfunction

  assign in_ready = (state_r == ST_IDLE) && !res_pend_r;

  always_comb begin
    logic              t_live;
    logic              p_live;
    logic              stall;
    logic [1:0]        need;
    logic [STEP_W-1:0] step_inc;
    logic [TOP_W-1:0]  top_dec;
    slot_rec_t         rec;
    logic [ID_W-1:0]   tid, pid;

    state_nxt    = state_r;
    res_pend_nxt = res_pend_r;
    in_nxt       = in_r;
    tlive_nxt    = tlive_r;
    plive_nxt    = plive_r;
    pchain_nxt   = pchain_r;
    cur_nxt      = cur_r;
    new_id_nxt   = new_id_r;
    clr_idx_nxt  = clr_idx_r;
    steps_nxt    = steps_r;
    wcnt_nxt     = wcnt_r;
    top_nxt      = top_r;
    fh_nxt       = fh_r;
    plink_nxt    = plink_r;
    rec_t_nxt    = rec_t_r;
    pop_mode_nxt = pop_mode_r;
    res_nxt      = res_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;

    s_we = 1'b0; s_waddr = '0; s_wdata = REC_CLEAR; s_re = 1'b0; s_raddr = '0;
    k_we = 1'b0; k_waddr = '0; k_wdata = '0;        k_re = 1'b0; k_raddr = '0;
    out_load      = 1'b0;
    out_load_data = res_r;

    t_live   = 1'b0;
    p_live   = 1'b0;
    stall    = 1'b0;
    need     = 2'd0;
    step_inc = steps_r + STEP_W'(1);
    top_dec  = top_r - TOP_W'(1);
    rec      = s_rdata;
    tid      = in_r.target_handle[ID_W-1:0];
    pid      = in_r.precondition_handle[ID_W-1:0];

    // finished single result goes out as soon as the register frees up
    if (res_pend_r && out_free) begin
      out_load     = 1'b1;
      res_pend_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        s_we        = 1'b1;
        s_waddr     = clr_idx_r;
        s_wdata     = REC_CLEAR;
        k_we        = 1'b1;
        k_waddr     = clr_idx_r;
        k_wdata     = clr_idx_r;
        clr_idx_nxt = clr_idx_r + ID_W'(1);
        if (clr_idx_r == LAST_ID) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid && !res_pend_r) begin
          in_nxt    = in_data;
          s_re      = 1'b1;
          s_raddr   = in_data.target_handle[ID_W-1:0];
          state_nxt = ST_T_CHK;
        end
      end
      ST_T_CHK: begin
        t_live    = in_r.target_valid && slot_live(s_rdata, in_r.target_handle);
        tlive_nxt = t_live;
        rec_t_nxt = s_rdata;
        res_nxt   = OUT_NONE;
        unique case (in_r.kind)
          KIND_INC: begin
            if (t_live) begin
              s_we    = 1'b1;
              s_waddr = tid;
              s_wdata = bump(s_rdata);
              res_nxt.handle_out       = in_r.target_handle;
              res_nxt.handle_out_valid = 1'b1;
              res_pend_nxt = 1'b1;
              state_nxt    = ST_IDLE;
            end else if (top_r == '0) begin
              res_nxt.status = STATUS_NO_SLOT;
              res_pend_nxt   = 1'b1;
              state_nxt      = ST_IDLE;
            end else begin
              pop_mode_nxt = POP_ALLOC;
              state_nxt    = ST_POP_RD;
            end
          end
          KIND_DEC: begin
            if (!t_live) begin
              res_nxt.status = STATUS_STALE;
              res_pend_nxt   = 1'b1;
              state_nxt      = ST_IDLE;
            end else if (s_rdata.count != COUNT_ONE) begin
              rec.count    = s_rdata.count - COUNT_ONE;
              s_we         = 1'b1;
              s_waddr      = tid;
              s_wdata      = rec;
              res_pend_nxt = 1'b1;
              state_nxt    = ST_IDLE;
            end else begin
              // count reaches zero: walk the chain from the head slot
              cur_nxt    = tid;
              steps_nxt  = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = ST_REL_WR;
            end
          end
          KIND_QUERY: begin
            res_nxt.is_zero = !t_live;
            res_pend_nxt    = 1'b1;
            state_nxt       = ST_IDLE;
          end
          KIND_SUBMIT: begin
            s_re      = 1'b1;
            s_raddr   = pid;
            state_nxt = ST_P_CHK;
          end
        endcase
      end
      ST_P_CHK: begin
        p_live     = in_r.precondition_valid && slot_live(s_rdata, in_r.precondition_handle);
        plive_nxt  = p_live;
        pchain_nxt = p_live && s_rdata.present;
        steps_nxt  = '0;
        wcnt_nxt   = '0;
        state_nxt  = (p_live && s_rdata.present) ? ST_CW_EV : ST_DECIDE;
      end
      ST_CW_EV: begin
        // count waiting jobs along the chain, read data holds the current slot
        wcnt_nxt  = wcnt_r + STEP_W'(s_rdata.present);
        steps_nxt = step_inc;
        if (!s_rdata.link[ID_W] && (step_inc < STEP_MAX)) begin
          s_re    = 1'b1;
          s_raddr = s_rdata.link[ID_W-1:0];
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        need = {1'b0, in_r.target_valid && !tlive_r} + {1'b0, pchain_r};
        if (pchain_r && (wcnt_r >= STEP_MAX)) begin
          res_nxt.status = STATUS_CHAIN_FULL;
          res_pend_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (top_r < TOP_W'(need)) begin
          res_nxt.status = STATUS_NO_SLOT;
          res_pend_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (in_r.target_valid) begin
          if (tlive_r) begin
            s_we      = 1'b1;
            s_waddr   = tid;
            s_wdata   = bump(rec_t_r);
            fh_nxt    = in_r.target_handle;
            state_nxt = ST_JOB;
          end else begin
            pop_mode_nxt = POP_FIN;
            state_nxt    = ST_POP_RD;
          end
        end else begin
          fh_nxt    = '0;
          state_nxt = ST_JOB;
        end
      end
      ST_JOB: begin
        res_nxt.handle_out       = fh_r;
        res_nxt.handle_out_valid = in_r.target_valid;
        if (!plive_r) begin
          // precondition absent or dead: job runs at once
          res_nxt.released          = 1'b1;
          res_nxt.rel_job_tag       = in_r.job_tag;
          res_nxt.rel_worker        = in_r.job_worker;
          res_nxt.rel_finish_handle = fh_r;
          res_nxt.rel_finish_valid  = in_r.target_valid;
          res_pend_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (!pchain_r) begin
          s_re      = 1'b1;
          s_raddr   = pid;
          state_nxt = ST_JW;
        end else begin
          pop_mode_nxt = POP_CHAIN;
          state_nxt    = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        top_nxt   = top_dec;
        k_re      = 1'b1;
        k_raddr   = top_dec[ID_W-1:0];
        state_nxt = ST_POP_SL;
      end
      ST_POP_SL: begin
        new_id_nxt = k_rdata;
        s_re       = 1'b1;
        s_raddr    = k_rdata;
        state_nxt  = ST_POP_WR;
      end
      ST_POP_WR: begin
        rec.count   = COUNT_ONE;
        rec.link    = LINK_NONE;
        rec.present = 1'b0;
        s_we        = 1'b1;
        s_waddr     = new_id_r;
        s_wdata     = rec;
        unique case (pop_mode_r)
          POP_ALLOC: begin
            res_nxt.handle_out       = {s_rdata.gen, IDF_W'(new_id_r)};
            res_nxt.handle_out_valid = 1'b1;
            res_pend_nxt = 1'b1;
            state_nxt    = ST_IDLE;
          end
          POP_FIN: begin
            fh_nxt    = {s_rdata.gen, IDF_W'(new_id_r)};
            state_nxt = ST_JOB;
          end
          default: begin
            s_re      = 1'b1;
            s_raddr   = pid;
            state_nxt = ST_LK_CAP;
          end
        endcase
      end
      ST_LK_CAP: begin
        plink_nxt = s_rdata.link;
        s_re      = 1'b1;
        s_raddr   = new_id_r;
        state_nxt = ST_CH_WR;
      end
      ST_CH_WR: begin
        // new chain slot takes the head's old link, head then points at it
        rec.link       = plink_r;
        rec.present    = 1'b1;
        rec.tag        = in_r.job_tag;
        rec.worker     = in_r.job_worker;
        rec.fin_valid  = in_r.target_valid;
        rec.fin_handle = fh_r;
        s_we           = 1'b1;
        s_waddr        = new_id_r;
        s_wdata        = rec;
        s_re           = 1'b1;
        s_raddr        = pid;
        state_nxt      = ST_PL_WR;
      end
      ST_PL_WR: begin
        rec.link     = {1'b0, new_id_r};
        s_we         = 1'b1;
        s_waddr      = pid;
        s_wdata      = rec;
        res_pend_nxt = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_JW: begin
        rec.present    = 1'b1;
        rec.tag        = in_r.job_tag;
        rec.worker     = in_r.job_worker;
        rec.fin_valid  = in_r.target_valid;
        rec.fin_handle = fh_r;
        s_we           = 1'b1;
        s_waddr        = pid;
        s_wdata        = rec;
        res_pend_nxt   = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_REL_WR: begin
        // one held job: it goes out only once the next one or the end is known
        stall = s_rdata.present && pend_v_r && !out_free;
        if (!stall) begin
          if (s_rdata.present) begin
            if (pend_v_r) begin
              out_load      = 1'b1;
              out_load_data = pend_r;
            end
            pend_nxt                   = OUT_NONE;
            pend_nxt.last              = 1'b0;
            pend_nxt.released          = 1'b1;
            pend_nxt.rel_job_tag       = s_rdata.tag;
            pend_nxt.rel_worker        = s_rdata.worker;
            pend_nxt.rel_finish_handle = s_rdata.fin_handle;
            pend_nxt.rel_finish_valid  = s_rdata.fin_valid;
            pend_v_nxt                 = 1'b1;
          end
          rec.gen     = s_rdata.gen + GEN_W'(1);
          rec.count   = '0;
          rec.present = 1'b0;
          rec.link    = LINK_NONE;
          s_we        = 1'b1;
          s_waddr     = cur_r;
          s_wdata     = rec;
          if (top_r < TOP_FULL) begin
            k_we    = 1'b1;
            k_waddr = top_r[ID_W-1:0];
            k_wdata = cur_r;
            top_nxt = top_r + TOP_W'(1);
          end
          steps_nxt = step_inc;
          if (!s_rdata.link[ID_W] && (step_inc < STEP_MAX)) begin
            cur_nxt = s_rdata.link[ID_W-1:0];
            s_re    = 1'b1;
            s_raddr = s_rdata.link[ID_W-1:0];
          end else begin
            state_nxt = ST_REL_END;
          end
        end
      end
      ST_REL_END: begin
        if (pend_v_r) begin
          res_nxt      = pend_r;
          res_nxt.last = 1'b1;
        end else begin
          res_nxt = OUT_NONE;
        end
        pend_v_nxt   = 1'b0;
        res_pend_nxt = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      res_pend_r <= 1'b0;
      clr_idx_r  <= '0;
      top_r      <= TOP_FULL;
      pend_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      res_pend_r <= res_pend_nxt;
      clr_idx_r  <= clr_idx_nxt;
      top_r      <= top_nxt;
      pend_v_r   <= pend_v_nxt;
    end
    in_r       <= in_nxt;
    tlive_r    <= tlive_nxt;
    plive_r    <= plive_nxt;
    pchain_r   <= pchain_nxt;
    cur_r      <= cur_nxt;
    new_id_r   <= new_id_nxt;
    steps_r    <= steps_nxt;
    wcnt_r     <= wcnt_nxt;
    fh_r       <= fh_nxt;
    plink_r    <= plink_nxt;
    rec_t_r    <= rec_t_nxt;
    pop_mode_r <= pop_mode_nxt;
    res_r      <= res_nxt;
    pend_r     <= pend_nxt;
  end

endmodule

### src/dct_checker.sv
// dct_checker: port-level assertions for dependency_counter_table
// uses dct_pkg; attached to the top level by the bind below
module dct_checker
  import dct_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // clearing pass blocks input right after reset
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during clearing pass");

  // one transaction at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  // only released jobs may be followed by more results
  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.released |-> out_data.last)
    else $error("non-release result without last");

  // an error result carries no handle and no job
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STATUS_OK) |->
      !out_data.released && !out_data.handle_out_valid)
    else $error("error result carries payload");

endmodule

bind dependency_counter_table dct_checker u_dct_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

### tb/sv/dependency_counter_table_tb.sv
// dependency_counter_table_tb: self-checking bench for the dependency counter table
// depends on dct_pkg and dependency_counter_table; predicts every result and
// compares it field by field with what the block returns
module dependency_counter_table_tb;
  import dct_pkg::*;

  localparam int POOL       = 4096;
  localparam int WAITER_CAP = 63;
  localparam int COUNT_TOP  = 65535;
  localparam int LINK_NONE  = 'h10000;
  localparam int CYCLE_CAP  = 4000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  dependency_counter_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // mirror of the slot table
  int unsigned slot_count [POOL];
  logic [15:0] slot_gen   [POOL];
  bit          job_parked [POOL];
  logic [31:0] parked_tag [POOL];
  logic [7:0]  parked_wk  [POOL];
  logic [32:0] parked_fin [POOL];
  int          next_link  [POOL];
  int          free_ids   [POOL];
  int          free_top;
  bit          ever_taken [POOL];   // slots whose count has been written

  in_item_t    pending_items[$];
  out_item_t   expected_results[$];
  logic [31:0] known_handles[$];    // recently handed out handles, stimulus pool
  logic [31:0] last_handle;

  int errors = 0;
  int cycles = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic bit handle_live(logic [31:0] h);
    int id;
    id = int'(h[15:0]);
    if (id >= POOL) return 1'b0;
    return slot_gen[id] == h[31:16] && slot_count[id] != 0;
  endfunction

  function automatic logic [31:0] take_free_slot();
    int id;
    free_top--;
    id = free_ids[free_top];
    slot_count[id] = 1;
    next_link[id] = LINK_NONE;
    job_parked[id] = 1'b0;
    ever_taken[id] = 1'b1;
    return {slot_gen[id], 16'(id)};
  endfunction

  function automatic int waiters_on(int head);
    int n, steps, cur;
    n = 0; steps = 0; cur = head;
    while (cur < POOL && steps < WAITER_CAP) begin
      if (job_parked[cur]) n++;
      cur = next_link[cur];
      steps++;
    end
    return n;
  endfunction

  function automatic void note_handle(logic [31:0] h);
    last_handle = h;
    known_handles = {known_handles, h};
    if (known_handles.size() > 24) void'(known_handles.pop_front());
  endfunction

  function automatic void expect_result(out_item_t r);
    expected_results = {expected_results, r};
  endfunction

  // works out the results of one accepted transaction and queues them
  function automatic void predict_results(in_item_t it);
    out_item_t r;
    bit t_live, p_live, need_chain;
    int tid, pid, need, cur, nxt, steps, n, slot;
    logic [31:0] fin;
    r = OUT_NONE;
    t_live = it.target_valid && handle_live(it.target_handle);
    tid = int'(it.target_handle[15:0]);
    case (it.kind)
      KIND_INC: begin
        if (t_live) begin
          if (slot_count[tid] < COUNT_TOP) slot_count[tid]++;
          r.handle_out = it.target_handle;
          r.handle_out_valid = 1'b1;
        end else if (free_top == 0) begin
          r.status = STATUS_NO_SLOT;
        end else begin
          r.handle_out = take_free_slot();
          r.handle_out_valid = 1'b1;
          note_handle(r.handle_out);
        end
        expect_result(r);
      end
      KIND_DEC: begin
        if (!t_live) begin
          r.status = STATUS_STALE;
          expect_result(r);
        end else begin
          slot_count[tid]--;
          if (slot_count[tid] != 0) begin
            expect_result(r);
          end else begin
            // release walk: emit parked jobs, retire every slot of the chain
            n = 0; steps = 0; cur = tid;
            while (cur < POOL && steps < WAITER_CAP) begin
              nxt = next_link[cur];
              steps++;
              if (job_parked[cur]) begin
                r = '0;
                r.released = 1'b1;
                r.rel_job_tag = parked_tag[cur];
                r.rel_worker = parked_wk[cur];
                r.rel_finish_handle = parked_fin[cur][31:0];
                r.rel_finish_valid = parked_fin[cur][32];
                expect_result(r);
                n++;
              end
              slot_gen[cur] = slot_gen[cur] + 16'd1;
              slot_count[cur] = 0;
              job_parked[cur] = 1'b0;
              next_link[cur] = LINK_NONE;
              if (free_top < POOL) begin
                free_ids[free_top] = cur;
                free_top++;
              end
              cur = nxt;
            end
            if (n == 0) expect_result(OUT_NONE);
            else expected_results[$].last = 1'b1;
          end
        end
      end
      KIND_QUERY: begin
        r.is_zero = !t_live;
        expect_result(r);
      end
      default: begin
        p_live = it.precondition_valid && handle_live(it.precondition_handle);
        pid = int'(it.precondition_handle[15:0]);
        need_chain = p_live && job_parked[pid];
        need = ((it.target_valid && !t_live) ? 1 : 0) + (need_chain ? 1 : 0);
        fin = '0;
        if (need_chain && waiters_on(pid) >= WAITER_CAP) begin
          r.status = STATUS_CHAIN_FULL;
        end else if (free_top < need) begin
          r.status = STATUS_NO_SLOT;
        end else begin
          if (it.target_valid) begin
            if (t_live) begin
              if (slot_count[tid] < COUNT_TOP) slot_count[tid]++;
              fin = it.target_handle;
            end else begin
              fin = take_free_slot();
              note_handle(fin);
            end
            r.handle_out = fin;
            r.handle_out_valid = 1'b1;
          end
          if (!p_live) begin
            // nothing to wait on: the job runs at once
            r.released = 1'b1;
            r.rel_job_tag = it.job_tag;
            r.rel_worker = it.job_worker;
            r.rel_finish_handle = fin;
            r.rel_finish_valid = it.target_valid;
          end else begin
            slot = pid;
            if (need_chain) begin
              slot = int'(take_free_slot() & 32'hFFFF);
              next_link[slot] = next_link[pid];
              next_link[pid] = slot;
            end
            job_parked[slot] = 1'b1;
            parked_tag[slot] = it.job_tag;
            parked_wk[slot] = it.job_worker;
            parked_fin[slot] = {it.target_valid, fin};
          end
        end
        expect_result(r);
      end
    endcase
  endfunction

  // driver: predicts at acceptance, then offers the next pending transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_results(in_data);
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here so the input side keeps pushing
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: every accepted result against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", 64'(out_data.handle_out), 64'(0));
      end else begin
        want = expected_results.pop_front();
        if (out_data.handle_out !== want.handle_out)
          report("handle_out", 64'(out_data.handle_out), 64'(want.handle_out));
        if (out_data.handle_out_valid !== want.handle_out_valid)
          report("handle_out_valid", 64'(out_data.handle_out_valid),
                 64'(want.handle_out_valid));
        if (out_data.is_zero !== want.is_zero)
          report("is_zero", 64'(out_data.is_zero), 64'(want.is_zero));
        if (out_data.released !== want.released)
          report("released", 64'(out_data.released), 64'(want.released));
        if (out_data.rel_job_tag !== want.rel_job_tag)
          report("rel_job_tag", 64'(out_data.rel_job_tag), 64'(want.rel_job_tag));
        if (out_data.rel_worker !== want.rel_worker)
          report("rel_worker", 64'(out_data.rel_worker), 64'(want.rel_worker));
        if (out_data.rel_finish_handle !== want.rel_finish_handle)
          report("rel_finish_handle", 64'(out_data.rel_finish_handle),
                 64'(want.rel_finish_handle));
        if (out_data.rel_finish_valid !== want.rel_finish_valid)
          report("rel_finish_valid", 64'(out_data.rel_finish_valid),
                 64'(want.rel_finish_valid));
        if (out_data.last !== want.last)
          report("last", 64'(out_data.last), 64'(want.last));
        if (out_data.status !== want.status)
          report("status", 64'(out_data.status), 64'(want.status));
      end
    end
    out_ready <= (hold_left == 0) && ($urandom_range(99) >= out_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // never point a generation-0 handle at a slot whose count was never written
  function automatic logic [31:0] safe_handle(logic [31:0] h);
    if (h[15:0] < POOL && !ever_taken[h[11:0]] && h[31:16] == 16'd0) h[31:16] = 16'd1;
    return h;
  endfunction

  task automatic queue_item(input logic [1:0] kind, input logic [31:0] th, input bit tv,
                            input logic [31:0] ph, input bit pv,
                            input logic [31:0] tag, input logic [7:0] wk);
    in_item_t it;
    while (pending_items.size() > 8) @(negedge clk);
    it.kind = kind;
    it.target_handle = safe_handle(th);
    it.target_valid = tv;
    it.precondition_handle = safe_handle(ph);
    it.precondition_valid = pv;
    it.job_tag = tag;
    it.job_worker = wk;
    pending_items = {pending_items, it};
  endtask

  // block idle: all stimulus taken and every expected result returned
  task automatic settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  function automatic logic [31:0] pick_handle();
    logic [31:0] h;
    int k;
    k = $urandom_range(99);
    if (known_handles.size() > 0 && k < 70) begin
      h = known_handles[$urandom_range(known_handles.size() - 1)];
    end else if (known_handles.size() > 0 && k < 85) begin
      // neighbor id, often a chain slot addressed directly, or a stale generation
      h = known_handles[$urandom_range(known_handles.size() - 1)];
      h[15:0] = h[15:0] - 16'($urandom_range(3));
      h[31:16] = h[31:16] + 16'($urandom_range(1));
    end else begin
      h = $urandom;
    end
    return h;
  endfunction

  task automatic random_items(input int n);
    int kind_pick;
    for (int i = 0; i < n; i++) begin
      kind_pick = $urandom_range(99);
      if (kind_pick < 25)
        queue_item(KIND_INC, pick_handle(), $urandom_range(3) != 0, $urandom,
                   1'($urandom), $urandom, 8'($urandom));
      else if (kind_pick < 50)
        queue_item(KIND_DEC, pick_handle(), $urandom_range(9) != 0, $urandom,
                   1'($urandom), $urandom, 8'($urandom));
      else if (kind_pick < 60)
        queue_item(KIND_QUERY, pick_handle(), $urandom_range(4) != 0, $urandom,
                   1'($urandom), $urandom, 8'($urandom));
      else
        queue_item(KIND_SUBMIT, pick_handle(), 1'($urandom_range(1)), pick_handle(),
                   $urandom_range(4) != 0, $urandom, 8'($urandom));
    end
  endtask

  initial begin
    logic [31:0] a, p;
    for (int i = 0; i < POOL; i++) begin
      slot_count[i] = 0; slot_gen[i] = '0; job_parked[i] = 1'b0;
      parked_tag[i] = '0; parked_wk[i] = '0; parked_fin[i] = '0;
      next_link[i] = LINK_NONE; free_ids[i] = i; ever_taken[i] = 1'b0;
    end
    free_top = POOL;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: allocate, live increment, queries, stale and absent handles
    in_idle_pct = 10; out_idle_pct = 78;
    queue_item(KIND_INC, '0, 1'b0, '0, 1'b0, '0, '0);
    settle();
    a = last_handle;
    queue_item(KIND_INC, a, 1'b1, '0, 1'b0, '0, '0);
    queue_item(KIND_QUERY, a, 1'b1, '0, 1'b0, '0, '0);
    queue_item(KIND_QUERY, a, 1'b0, '0, 1'b0, '0, '0);
    queue_item(KIND_QUERY, 32'h0001_FFFF, 1'b1, '0, 1'b0, '0, '0);
    queue_item(KIND_DEC, a, 1'b0, '0, 1'b0, '0, '0);
    queue_item(KIND_DEC, {a[31:16] + 16'd5, a[15:0]}, 1'b1, '0, 1'b0, '0, '0);
    queue_item(KIND_SUBMIT, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 8'hFF);
    queue_item(KIND_INC, '0, 1'b0, '0, 1'b0, '0, '0);
    settle();
    p = last_handle;
    // three jobs parked on p: head slot, then two chained slots
    queue_item(KIND_SUBMIT, 32'hFFFF_FFFF, 1'b1, p, 1'b1, '0, '0);
    queue_item(KIND_SUBMIT, '0, 1'b0, p, 1'b1, 32'h1234_5678, 8'h0F);
    queue_item(KIND_SUBMIT, a, 1'b1, p, 1'b1, 32'h8000_0001, 8'hF0);
    queue_item(KIND_QUERY, p, 1'b1, '0, 1'b0, '0, '0);
    queue_item(KIND_DEC, p, 1'b1, '0, 1'b0, '0, '0);
    queue_item(KIND_QUERY, p, 1'b1, '0, 1'b0, '0, '0);
    queue_item(KIND_DEC, a, 1'b1, '0, 1'b0, '0, '0);
    queue_item(KIND_DEC, a, 1'b1, '0, 1'b0, '0, '0);
    queue_item(KIND_DEC, a, 1'b1, '0, 1'b0, '0, '0);
    queue_item(KIND_DEC, a, 1'b1, '0, 1'b0, '0, '0);

    random_items(70);
    settle();
    in_idle_pct = 78; out_idle_pct = 10;
    random_items(70);
    settle();
    in_idle_pct = 0; out_idle_pct = 0;
    hold_go = 1'b1;   // receiver stalls while the sender keeps offering
    random_items(80);
    settle();

    // chain full: one live signal with 63 waiters, the two submits after them are refused
    queue_item(KIND_INC, '0, 1'b0, '0, 1'b0, '0, '0);
    settle();
    p = last_handle;
    for (int i = 0; i < WAITER_CAP + 2; i++)
      queue_item(KIND_SUBMIT, '0, 1'b0, p, 1'b1, $urandom, 8'($urandom));
    queue_item(KIND_DEC, p, 1'b1, '0, 1'b0, '0, '0);
    settle();

    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
src/dct_pkg.sv
src/dct_ram.sv
src/dct_out_reg.sv
src/dependency_counter_table.sv
src/dct_checker.sv
tb/sv/dependency_counter_table_tb.sv
